// ===== design/svm_pkg.sv =====
// Package: opcodes, controller states and controller/datapath command types.
`default_nettype none
package svm_pkg;

	typedef enum logic [4:0] {
		OP_ADD  = 5'd0,  OP_AND  = 5'd1,  OP_CALL = 5'd2,  OP_DIV  = 5'd3,
		OP_HCF  = 5'd4,  OP_JIL  = 5'd5,  OP_JMP  = 5'd6,  OP_JNE  = 5'd7,
		OP_LB   = 5'd8,  OP_LD   = 5'd9,  OP_LW   = 5'd10, OP_MOD  = 5'd11,
		OP_MUL  = 5'd12, OP_NOT  = 5'd13, OP_POP  = 5'd14, OP_PUSH = 5'd15,
		OP_RET  = 5'd16, OP_SB   = 5'd17, OP_SHIL = 5'd18, OP_SHIR = 5'd19,
		OP_SW   = 5'd20, OP_SUB  = 5'd21
	} opcode_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_LOAD, ST_FETCH, ST_EXEC, ST_MEMRD, ST_MEMWR, ST_DIV, ST_DONE
	} state_t;

	localparam int unsigned DIV_STEPS = 16;

	// controller -> datapath
	typedef struct packed {
		logic       take_in;     // capture input transaction
		logic       do_load;     // write load byte
		logic       fetch_rd;    // read fetch byte fcnt
		logic       exec;        // decode, capture operands
		logic       mem_rd;      // data read byte mcnt
		logic       mem_wr;      // data write byte mcnt
		logic       div_step;    // one divider iteration
		logic       finish;      // commit results, build output
		logic       halted_out;  // step on halted machine / load
		logic [1:0] cnt;         // byte index
	} svm_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic       is_step;
		logic       halted;
		logic       need_rd;
		logic       need_wr;
		logic       two_bytes;
		logic       need_div;
	} svm_sts_t;

endpackage
`default_nettype wire

// ===== design/svm_if.sv =====
// Valid/ready channel interface.
`default_nettype none
interface svm_if #(parameter int unsigned W = 8) (input wire logic clk);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/svm_ctrl.sv =====
// Controller state machine sequencing fetch, execute, memory and divide.
`default_nettype none
module svm_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire logic            out_ready,
	input  wire svm_pkg::svm_sts_t sts,
	output svm_pkg::svm_cmd_t    cmd
);
	import svm_pkg::*;

	state_t     state_q, state_d;
	logic [4:0] cnt_q, cnt_d;
	logic       ovalid_q, ovalid_d;

	logic finish_ev;
	logic [4:0] rd_last;

	// byte reads land two registers later (rdata_q, then ld_q): the count runs one past the last request
	assign rd_last = sts.two_bytes ? 5'd2 : 5'd1;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				cnt_d = '0;
				if (!sts.is_step) state_d = ST_DONE;
				else if (sts.halted) state_d = ST_DONE;
				else state_d = ST_FETCH;
			end
			ST_FETCH: begin
				cnt_d = cnt_q + 5'd1;
				// four reads, then a spare state at count 4 for the last byte to land in the word
				if (cnt_q == 5'd4) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cnt_d = '0;
				if (sts.need_rd) state_d = ST_MEMRD;
				else if (sts.need_wr) state_d = ST_MEMWR;
				else if (sts.need_div) state_d = ST_DIV;
				else state_d = ST_DONE;
			end
			ST_MEMRD: begin
				cnt_d = cnt_q + 5'd1;
				if (cnt_q == rd_last) state_d = ST_DONE;
			end
			ST_MEMWR: begin
				cnt_d = cnt_q + 5'd1;
				if (!sts.two_bytes || cnt_q == 5'd1) state_d = ST_DONE;
			end
			ST_DIV: begin
				cnt_d = cnt_q + 5'd1;
				if (cnt_q == 5'(DIV_STEPS - 1)) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!ovalid_q || out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign finish_ev = (state_q == ST_DONE) && (!ovalid_q || out_ready);

	always_comb begin
		cmd          = '0;
		cmd.cnt      = cnt_q[1:0];
		in_ready     = (state_q == ST_IDLE);
		cmd.take_in  = in_ready && in_valid;
		unique case (state_q)
			ST_LOAD:  cmd.do_load = !sts.is_step;
			ST_FETCH: cmd.fetch_rd = (cnt_q < 5'd4);
			ST_EXEC:  cmd.exec = 1'b1;
			ST_MEMRD: cmd.mem_rd = (cnt_q < rd_last);
			ST_MEMWR: cmd.mem_wr = 1'b1;
			ST_DIV:   cmd.div_step = 1'b1;
			ST_DONE:  cmd.finish = finish_ev;
			default: ;
		endcase
		cmd.halted_out = !sts.is_step || sts.halted;
	end

	always_comb begin
		ovalid_d = ovalid_q;
		if (out_ready) ovalid_d = 1'b0;
		if (finish_ev) ovalid_d = 1'b1;
	end
	assign out_valid = ovalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			ovalid_q <= ovalid_d;
		end
	end
endmodule
`default_nettype wire

// ===== design/svm_dp.sv =====
// Datapath: register file, byte RAM, ALU and iterative divider.
`default_nettype none
module svm_dp #(
	parameter int unsigned ADDR_BITS   = 16,
	parameter int unsigned IP_REG      = 15,
	parameter int unsigned STACK_REG   = 14,
	parameter int unsigned FLAGS_REG   = 13,
	parameter int unsigned INSTR_BYTES = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [24:0]       in_data,
	input  wire svm_pkg::svm_cmd_t cmd,
	output svm_pkg::svm_sts_t      sts,
	output logic [35:0]            out_data
);
	import svm_pkg::*;

	localparam logic [3:0] IPR = 4'(IP_REG);
	localparam logic [3:0] SPR = 4'(STACK_REG);
	localparam logic [3:0] FLR = 4'(FLAGS_REG);

	logic [7:0]  mem [2**ADDR_BITS];
	logic [15:0] rf_q [16];
	logic        halt_q;

	logic        op_q;
	logic [15:0] laddr_q;
	logic [7:0]  lbyte_q;
	logic [31:0] word_q;
	logic [7:0]  rdata_q;
	logic [1:0]  rcnt_q;
	logic        rpend_q;

	// decoded, registered in exec
	opcode_t     code;
	logic [3:0]  d_w, s_w;
	logic [15:0] imm_w, first_w, second_w, r_w;
	logic [3:0]  d_q;
	logic [15:0] first_q, second_q, r_q;
	logic [4:0]  code_q;
	logic [15:0] maddr_q, wval_q;

	// divider
	logic [15:0] quo_q, rem_q;

	logic [ADDR_BITS-1:0] faddr, daddr;

	// decode is stable from exec until finish
	assign sts.is_step   = op_q;
	assign sts.halted    = halt_q;
	assign sts.need_rd   = code == OP_LB || code == OP_LW || code == OP_POP || code == OP_RET;
	assign sts.need_wr   = code == OP_CALL || code == OP_PUSH || code == OP_SB || code == OP_SW;
	assign sts.two_bytes = !(code == OP_LB || code == OP_SB);
	assign sts.need_div  = (code == OP_DIV || code == OP_MOD) && second_w != 16'd0;

	assign code  = opcode_t'(word_q[31:27]);
	assign d_w   = word_q[19:16];
	assign s_w   = word_q[25:22];
	assign imm_w = word_q[15:0];
	always_comb begin
		if (word_q[21]) begin
			first_w  = imm_w;
			second_w = rf_q[s_w];
		end else if (word_q[26]) begin
			first_w  = rf_q[d_w];
			second_w = imm_w;
		end else begin
			first_w  = rf_q[d_w];
			second_w = rf_q[s_w];
		end
	end
	assign r_w = rf_q[d_w];

	assign faddr = ADDR_BITS'(rf_q[IPR] + 16'(cmd.cnt));
	assign daddr = ADDR_BITS'(maddr_q + 16'(cmd.cnt));

	// memory: one port, read data registered
	always_ff @(posedge clk) begin
		if (cmd.do_load) mem[ADDR_BITS'(laddr_q)] <= lbyte_q;
		else if (cmd.mem_wr) mem[daddr] <= (cmd.cnt[0] ? wval_q[15:8] : wval_q[7:0]);
		if (cmd.fetch_rd) rdata_q <= mem[faddr];
		else rdata_q <= mem[daddr];
	end

	always_ff @(posedge clk) begin
		logic [16:0] tr;
		if (cmd.take_in) begin
			op_q    <= in_data[0];
			laddr_q <= in_data[16:1];
			lbyte_q <= in_data[24:17];
		end
		rcnt_q  <= cmd.cnt;
		rpend_q <= cmd.fetch_rd;
		if (rpend_q) word_q[8*rcnt_q +: 8] <= rdata_q;
		if (cmd.exec) begin
			d_q      <= d_w;
			first_q  <= first_w;
			second_q <= second_w;
			r_q      <= r_w;
			code_q   <= code;
			quo_q    <= r_w;
			rem_q    <= '0;
			unique case (code)
				OP_CALL, OP_PUSH: maddr_q <= rf_q[SPR] - 16'd2;
				OP_POP, OP_RET:   maddr_q <= rf_q[SPR];
				OP_SB, OP_SW:     maddr_q <= r_w;
				default:          maddr_q <= second_w;
			endcase
			unique case (code)
				OP_CALL: wval_q <= rf_q[IPR] + 16'(INSTR_BYTES);
				OP_PUSH: wval_q <= first_w;
				default: wval_q <= second_w;
			endcase
		end
		if (cmd.div_step) begin
			tr = {rem_q, quo_q[15]} - {1'b0, second_q};
			if (!tr[16]) begin
				rem_q <= tr[15:0];
				quo_q <= {quo_q[14:0], 1'b1};
			end else begin
				rem_q <= {rem_q[14:0], quo_q[15]};
				quo_q <= {quo_q[14:0], 1'b0};
			end
		end
	end

	// byte read lands in rdata_q in the cycle after its request; capture one or both data bytes
	logic        mrd_pend_q;
	logic        mrd_cnt_q;
	logic [15:0] ld_q;
	always_ff @(posedge clk) begin
		mrd_pend_q <= cmd.mem_rd;
		mrd_cnt_q  <= cmd.cnt[0];
		if (mrd_pend_q) begin
			if (mrd_cnt_q) ld_q[15:8] <= rdata_q;
			else ld_q <= {8'h00, rdata_q};
		end
	end

	// finish: result computed from registered operands; ld_q is complete
	// because the read state runs its count one past the last request.
	logic [15:0] res, sp_new, ip_new, flg;
	logic        wr_d, setf, jump, fault, hcf, wr_sp;
	always_comb begin
		res = r_q; wr_d = 1'b0; setf = 1'b0; jump = 1'b0; fault = 1'b0; hcf = 1'b0;
		wr_sp = 1'b0; sp_new = rf_q[SPR]; ip_new = rf_q[IPR];
		case (code_q)
			OP_ADD:  begin res = r_q + second_q; wr_d = 1; setf = 1; end
			OP_AND:  begin res = r_q & second_q; wr_d = 1; setf = 1; end
			OP_SUB:  begin res = r_q - second_q; wr_d = 1; setf = 1; end
			OP_MUL:  begin res = 16'(r_q * second_q); wr_d = 1; setf = 1; end
			OP_DIV, OP_MOD: begin
				wr_d = 1; setf = 1;
				if (second_q == 16'd0) begin res = 16'hFFFF; fault = 1; end
				else res = (code_q == OP_DIV) ? quo_q : rem_q;
			end
			OP_SHIL: begin
				res = (second_q >= 16'd16) ? 16'd0 : (r_q << second_q[3:0]);
				wr_d = 1; setf = 1;
			end
			OP_SHIR: begin
				res = (second_q >= 16'd16) ? 16'd0 : (r_q >> second_q[3:0]);
				wr_d = 1; setf = 1;
			end
			OP_NOT:  begin res = ~r_q; wr_d = 1; end
			OP_LD:   begin res = second_q; wr_d = 1; end
			OP_LB:   begin res = {8'h00, ld_q[7:0]}; wr_d = 1; end
			OP_LW:   begin res = ld_q; wr_d = 1; end
			OP_POP:  begin res = ld_q; wr_d = 1; wr_sp = 1; sp_new = maddr_q + 16'd2; end
			OP_RET:  begin jump = 1; wr_sp = 1; sp_new = maddr_q + 16'd2; ip_new = ld_q; end
			OP_CALL: begin jump = 1; wr_sp = 1; sp_new = maddr_q; ip_new = first_q; end
			OP_PUSH: begin wr_sp = 1; sp_new = maddr_q; end
			OP_JMP:  begin jump = 1; ip_new = first_q; end
			OP_JIL:  if (rf_q[FLR][1]) begin jump = 1; ip_new = first_q; end
			OP_JNE:  if (!rf_q[FLR][0]) begin jump = 1; ip_new = first_q; end
			OP_HCF:  begin hcf = 1; jump = 1; end
			default: ;
		endcase
		flg = {14'd0, res[15], res == 16'd0};
	end

	logic [15:0] rf_n [16];
	always_comb begin
		for (int i = 0; i < 16; i++) rf_n[i] = rf_q[i];
		if (wr_sp) rf_n[SPR] = sp_new;
		if (code_q == OP_CALL) rf_n[IPR] = wval_q;
		if (wr_d) rf_n[d_q] = res;
		if (setf) rf_n[FLR] = flg;
		if (jump) rf_n[IPR] = ip_new;
		else rf_n[IPR] = rf_n[IPR] + 16'(INSTR_BYTES);
	end

	logic [35:0] odata_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) rf_q[i] <= '0;
			halt_q <= 1'b0;
		end else if (cmd.finish && !cmd.halted_out) begin
			for (int i = 0; i < 16; i++) rf_q[i] <= rf_n[i];
			if (hcf) halt_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (cmd.halted_out)
				odata_q <= {1'b0, halt_q, 16'd0, rf_q[FLR][1], rf_q[FLR][0], rf_q[IPR]};
			else
				odata_q <= {fault, halt_q | hcf, rf_n[d_q], rf_n[FLR][1], rf_n[FLR][0],
					rf_n[IPR]};
		end
	end
	assign out_data = odata_q;
endmodule
`default_nettype wire

// ===== design/sixteen_bit_vm_cpu_step_core.sv =====
// Top level: 16-bit register machine, one instruction or program byte per transaction.
// Usage:
//  - in channel (svm_if sink): operation, load_address, load_byte. operation=0
//    writes one RAM byte, operation=1 executes one instruction at IP.
//  - out channel (svm_if source): one result transaction per input transaction:
//    IP, zero/sign flags, op1 register value, halt mark, divide fault.
//  - Sequence: a load goes LOAD, DONE; an instruction makes four serial byte
//    fetches on the single RAM port plus a spare state for the last byte, then
//    EXEC, then data reads for LB (one byte) or LW/POP/RET (two bytes) plus a
//    spare state, writes for SB (one byte) or SW/PUSH/CALL (two), or the radix-2
//    divider for DIV/MOD by nonzero, then DONE. A step on a halted machine goes
//    LOAD, DONE. One transaction in flight; the next can be accepted once the result is valid.
//  - The result register holds the last result; the next input is taken
//    while it waits, but the core stalls before committing another result
//    until the receiver takes it.
//  - Reset clears registers, halt mark and control; RAM is not cleared and
//    must be written before it is read.
`default_nettype none
module sixteen_bit_vm_cpu_step_core #(
	parameter int unsigned ADDR_BITS   = 16,
	parameter int unsigned IP_REG      = 15,
	parameter int unsigned STACK_REG   = 14,
	parameter int unsigned FLAGS_REG   = 13,
	parameter int unsigned INSTR_BYTES = 4
) (
	input wire logic clk,
	input wire logic arst_n,
	svm_if.sink      in_ch,
	svm_if.source    out_ch
);
	import svm_pkg::*;

	svm_cmd_t cmd;
	svm_sts_t sts;

	svm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.sts(sts), .cmd(cmd)
	);

	// in data: {load_byte, load_address, operation}
	// out data: {divide_fault, halted, dest_value, sign, zero, instr_pointer}
	svm_dp #(
		.ADDR_BITS(ADDR_BITS), .IP_REG(IP_REG), .STACK_REG(STACK_REG),
		.FLAGS_REG(FLAGS_REG), .INSTR_BYTES(INSTR_BYTES)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .in_data(in_ch.data[24:0]),
		.cmd(cmd), .sts(sts), .out_data(out_ch.data[35:0])
	);
endmodule
`default_nettype wire

// ===== design/svm_checker.sv =====
// Port-level checker bound to the top level.
`default_nettype none
module svm_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [35:0] out_data
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output changed while stalled");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("accepted twice back to back");
	a_halt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_data[34] |=> ##0 (!out_valid || out_data[34]))
		else $error("halt mark cleared");
endmodule

bind sixteen_bit_vm_cpu_step_core svm_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_data(out_ch.data[35:0])
);
`default_nettype wire

// ===== bench/tb_sixteen_bit_vm_cpu_step_core.sv =====
// Testbench for the 16-bit register machine core: predicted results vs. DUT output.
`default_nettype none
module tb_sixteen_bit_vm_cpu_step_core;
	timeunit 1ns;
	timeprecision 1ps;
	import svm_pkg::*;

	localparam int unsigned IPR = 15;
	localparam int unsigned SPR = 14;
	localparam int unsigned FLR = 13;
	localparam int unsigned RAND_ITEMS = 1500;
	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned DRAIN_CYCLES = 60;

	// input transaction: {load_byte, load_address, operation}
	typedef struct packed {
		logic [7:0]  lbyte;
		logic [15:0] addr;
		logic        op;
	} cmd_t;

	// output transaction: {divide fault, halted, op1 value, sign, zero, ip}
	typedef struct packed {
		logic        fault;
		logic        halt;
		logic [15:0] dest;
		logic        sf;
		logic        zf;
		logic [15:0] ip;
	} res_t;

	logic clk;
	logic arst_n;

	svm_if #(.W(25)) in_ch (clk);
	svm_if #(.W(36)) out_ch (clk);

	sixteen_bit_vm_cpu_step_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// shadow machine state
	logic [15:0] regs [16];
	logic [7:0]  ram [65536];
	bit          ram_ok [65536];   // byte has been written at least once
	bit          halt_m;

	res_t        pending_res [$];  // results still owed by the DUT
	int unsigned errors = 0;
	int unsigned n_sent = 0;
	int unsigned n_steps = 0;
	int unsigned n_got = 0;
	int unsigned n_faults = 0;
	int unsigned cycles = 0;
	int unsigned send_idle = 0;    // percent of cycles the sender sits idle
	int unsigned recv_stall = 0;   // percent of cycles the receiver stalls

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// every DUT input known from time zero
	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// receiver backpressure, changed only on the falling edge
	always @(negedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= recv_stall);
	end

	// run-away guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t timeout after %0d cycles, %0d results pending",
				$time, cycles, pending_res.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// result checker: compare each output transaction with the oldest prediction
	always @(posedge clk) begin
		res_t got, want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = res_t'(out_ch.data);
			n_got++;
			if (pending_res.size() == 0) begin
				errors++;
				$display("%0t unexpected result: expected none, actual %h", $time, got);
			end else begin
				want = pending_res.pop_front();
				if (got.ip !== want.ip) begin
					errors++;
					$display("%0t ip: expected %h actual %h", $time, want.ip, got.ip);
				end
				if (got.zf !== want.zf) begin
					errors++;
					$display("%0t zero flag: expected %b actual %b", $time, want.zf, got.zf);
				end
				if (got.sf !== want.sf) begin
					errors++;
					$display("%0t sign flag: expected %b actual %b", $time, want.sf, got.sf);
				end
				if (got.dest !== want.dest) begin
					errors++;
					$display("%0t dest: expected %h actual %h", $time, want.dest, got.dest);
				end
				if (got.halt !== want.halt) begin
					errors++;
					$display("%0t halted: expected %b actual %b", $time, want.halt, got.halt);
				end
				if (got.fault !== want.fault) begin
					errors++;
					$display("%0t div fault: expected %b actual %b",
						$time, want.fault, got.fault);
				end
			end
		end
	end

	function automatic logic [7:0] rd8(logic [15:0] a);
		return ram[a];
	endfunction

	function automatic logic [15:0] rd16(logic [15:0] a);
		return {ram[16'(a + 16'd1)], ram[a]};
	endfunction

	function automatic void wr8(logic [15:0] a, logic [7:0] v);
		ram[a] = v;
		ram_ok[a] = 1'b1;
	endfunction

	function automatic void wr16(logic [15:0] a, logic [15:0] v);
		wr8(a, v[7:0]);
		wr8(16'(a + 16'd1), v[15:8]);
	endfunction

	function automatic logic [31:0] fetch_word(logic [15:0] ip);
		return {rd8(16'(ip + 16'd3)), rd8(16'(ip + 16'd2)), rd8(16'(ip + 16'd1)), rd8(ip)};
	endfunction

	// operand select shared by predictor and read planner
	function automatic void decode(input logic [31:0] w, output logic [3:0] d,
		output logic [15:0] first, output logic [15:0] second);
		logic [5:0] op1;
		logic [4:0] op2;
		op1 = w[21:16];
		op2 = w[26:22];
		d = op1[3:0];
		if (op1[5]) begin
			first = w[15:0];
			second = regs[op2[3:0]];
		end else if (op2[4]) begin
			first = regs[d];
			second = w[15:0];
		end else begin
			first = regs[d];
			second = regs[op2[3:0]];
		end
	endfunction

	function automatic void set_flags(logic [15:0] v);
		regs[FLR] = {14'd0, v[15], (v == 16'd0)};
	endfunction

	// predicted machine: applies one transaction, returns the result it owes
	function automatic res_t machine_step(cmd_t c);
		res_t o;
		logic [31:0] w;
		logic [15:0] first, second, r, sp, v;
		logic [3:0] d;
		bit fault, jumped, ran;
		fault = 1'b0;
		jumped = 1'b0;
		d = '0;
		ran = c.op && !halt_m;
		if (!c.op) begin
			wr8(c.addr, c.lbyte);
		end else if (!halt_m) begin
			w = fetch_word(regs[IPR]);
			decode(w, d, first, second);
			r = regs[d];
			case (opcode_t'(w[31:27]))
				OP_ADD: begin r = r + second; regs[d] = r; set_flags(r); end
				OP_AND: begin r = r & second; regs[d] = r; set_flags(r); end
				OP_SUB: begin r = r - second; regs[d] = r; set_flags(r); end
				OP_MUL: begin r = 16'(r * second); regs[d] = r; set_flags(r); end
				OP_DIV, OP_MOD: begin
					if (second == 16'd0) begin
						r = 16'hFFFF;
						fault = 1'b1;
					end else if (opcode_t'(w[31:27]) == OP_DIV) r = r / second;
					else r = r % second;
					regs[d] = r;
					set_flags(r);
				end
				OP_CALL: begin
					sp = regs[SPR] - 16'd2;
					regs[SPR] = sp;
					regs[IPR] = regs[IPR] + 16'd4;
					wr16(sp, regs[IPR]);
					regs[IPR] = first;
					jumped = 1'b1;
				end
				OP_HCF: begin halt_m = 1'b1; jumped = 1'b1; end
				OP_JIL: if (regs[FLR][1]) begin regs[IPR] = first; jumped = 1'b1; end
				OP_JMP: begin regs[IPR] = first; jumped = 1'b1; end
				OP_JNE: if (!regs[FLR][0]) begin regs[IPR] = first; jumped = 1'b1; end
				OP_LB: regs[d] = {8'd0, rd8(second)};
				OP_LD: regs[d] = second;
				OP_LW: regs[d] = rd16(second);
				OP_NOT: regs[d] = ~r;
				OP_POP: begin
					sp = regs[SPR];
					v = rd16(sp);
					regs[SPR] = sp + 16'd2;
					regs[d] = v;
				end
				OP_PUSH: begin
					sp = regs[SPR] - 16'd2;
					regs[SPR] = sp;
					wr16(sp, first);
				end
				OP_RET: begin
					sp = regs[SPR];
					v = rd16(sp);
					regs[SPR] = sp + 16'd2;
					regs[IPR] = v;
					jumped = 1'b1;
				end
				OP_SB: wr8(regs[d], second[7:0]);
				OP_SHIL: begin
					r = (second >= 16'd16) ? 16'd0 : 16'(r << second);
					regs[d] = r;
					set_flags(r);
				end
				OP_SHIR: begin
					r = (second >= 16'd16) ? 16'd0 : (r >> second);
					regs[d] = r;
					set_flags(r);
				end
				OP_SW: wr16(regs[d], second);
				default: ;  // unused opcodes only advance IP
			endcase
			if (!jumped) regs[IPR] = regs[IPR] + 16'd4;
		end
		o.ip = regs[IPR];
		o.zf = regs[FLR][0];
		o.sf = regs[FLR][1];
		o.dest = ran ? regs[d] : 16'd0;
		o.halt = halt_m;
		o.fault = fault;
		return o;
	endfunction

	// drive one transaction; sender gaps land at the falling edge
	task automatic send(cmd_t c, bit typed = 1'b0, res_t typed_res = '0);
		res_t p;
		while ($urandom_range(99) < send_idle) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.data = c;
		do @(posedge clk); while (!in_ch.ready);
		p = machine_step(c);
		pending_res.push_back(typed ? typed_res : p);
		n_sent++;
		if (c.op) n_steps++;
		if (p.fault) n_faults++;
		@(negedge clk);
	endtask

	task automatic load_byte_at(logic [15:0] a, logic [7:0] v);
		cmd_t c;
		c.op = 1'b0;
		c.addr = a;
		c.lbyte = v;
		send(c);
	endtask

	// one instruction: place code at IP unless reusing, back-fill any data bytes
	// the instruction will read, then issue the execute transaction
	task automatic run_instr(logic [31:0] w, bit reuse);
		logic [15:0] ip, first, second, sp;
		logic [15:0] rd_addr [$];
		logic [31:0] cur;
		logic [3:0] d;
		bit keep_old;
		cmd_t c;
		ip = regs[IPR];
		keep_old = reuse && ram_ok[ip] && ram_ok[16'(ip + 16'd1)] && ram_ok[16'(ip + 16'd2)]
			&& ram_ok[16'(ip + 16'd3)];
		cur = w;
		if (keep_old) begin
			cur = fetch_word(ip);
			if (opcode_t'(cur[31:27]) == OP_HCF) keep_old = 1'b0;
		end
		if (!keep_old) begin
			for (int k = 0; k < 4; k++)
				load_byte_at(16'(ip + 16'(k)), w[8*k +: 8]);
			cur = w;
		end
		decode(cur, d, first, second);
		sp = regs[SPR];
		case (opcode_t'(cur[31:27]))
			OP_LB: rd_addr.push_back(second);
			OP_LW: begin rd_addr.push_back(second); rd_addr.push_back(16'(second + 16'd1)); end
			OP_POP, OP_RET: begin rd_addr.push_back(sp); rd_addr.push_back(16'(sp + 16'd1)); end
			default: ;
		endcase
		foreach (rd_addr[i])
			if (!ram_ok[rd_addr[i]]) load_byte_at(rd_addr[i], 8'($urandom));
		c.op = 1'b1;
		c.addr = 16'($urandom);
		c.lbyte = 8'($urandom);
		send(c);
	endtask

	function automatic logic [31:0] iw(logic [4:0] code, logic [4:0] b, logic [5:0] a,
		logic [15:0] imm);
		return {code, b, a, imm};
	endfunction

	function automatic logic [31:0] random_word();
		logic [4:0] code;
		logic [15:0] imm;
		if ($urandom_range(99) < 90) begin
			code = 5'($urandom_range(0, 20));
			if (code >= OP_HCF) code = code + 5'd1;  // halt only at the very end
		end else code = 5'($urandom_range(22, 31));
		case ($urandom_range(3))
			0: imm = 16'd0;
			1: imm = 16'($urandom_range(0, 20));
			2: imm = {$urandom_range(1) ? 8'hFF : 8'h00, 8'($urandom)};
			default: imm = 16'($urandom);
		endcase
		return {code, 5'($urandom), 6'($urandom), imm};
	endfunction

	// directed program: every opcode except HCF, operand modes, extremes and corner cases
	logic [31:0] dir_prog [] = '{
		iw(OP_LD,   5'h10, 6'd1,  16'hFFFF),
		iw(OP_LD,   5'h10, 6'd2,  16'h8000),
		iw(OP_ADD,  5'd2,  6'd1,  16'h0000),
		iw(OP_SUB,  5'h10, 6'd3,  16'h0000),
		iw(OP_AND,  5'h10, 6'd1,  16'h00F0),
		iw(OP_MUL,  5'd2,  6'd2,  16'h0000),
		iw(OP_DIV,  5'h10, 6'd1,  16'h0000),   // divide by zero
		iw(OP_MOD,  5'h10, 6'd1,  16'h0000),   // modulo by zero
		iw(OP_LD,   5'h10, 6'd4,  16'h0007),
		iw(OP_DIV,  5'h10, 6'd4,  16'h0002),
		iw(OP_MOD,  5'h10, 6'd1,  16'h0007),
		iw(OP_NOT,  5'd0,  6'd5,  16'h0000),
		iw(OP_SHIL, 5'h10, 6'd1,  16'h0010),   // shift count 16
		iw(OP_SHIR, 5'h10, 6'd5,  16'h0001),
		iw(OP_LD,   5'h10, 6'd14, 16'h0100),
		iw(OP_PUSH, 5'd0,  6'h20, 16'h1234),
		iw(OP_POP,  5'd0,  6'd6,  16'h0000),
		iw(OP_SB,   5'h10, 6'd14, 16'h00AB),
		iw(OP_LB,   5'h10, 6'd7,  16'h0100),
		iw(OP_SW,   5'h10, 6'd14, 16'hBEEF),
		iw(OP_LW,   5'h10, 6'd8,  16'h0100),
		iw(OP_ADD,  5'h10, 6'h1D, 16'h0001),   // op1 wider than 4 bits, hits flags
		iw(OP_JNE,  5'd0,  6'h20, 16'h0200),
		iw(OP_JIL,  5'd0,  6'h20, 16'h0300),
		iw(OP_CALL, 5'd0,  6'h20, 16'h0040),
		iw(OP_RET,  5'd0,  6'd0,  16'h0000),
		iw(OP_LD,   5'h10, 6'd15, 16'hFFFA),   // IP write, fetch wraps
		iw(5'd27,   5'h1F, 6'h1F, 16'hFFFF),   // unused opcode
		iw(OP_JMP,  5'd0,  6'h20, 16'h0000)
	};

	initial begin
		cmd_t c;
		int unsigned phase;
		for (int i = 0; i < 16; i++) regs[i] = '0;
		halt_m = 1'b0;
		@(posedge arst_n);
		@(negedge clk);

		// first transaction after reset: top byte of RAM, known result
		c.op = 1'b0;
		c.addr = 16'hFFFF;
		c.lbyte = 8'hFF;
		send(c, 1'b1, '0);
		foreach (dir_prog[i]) run_instr(dir_prog[i], 1'b0);

		// random part, four idling phases
		while (n_sent < RAND_ITEMS) begin
			phase = (n_sent * 4 / RAND_ITEMS) % 4;
			case (phase)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 71; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 71; end
				default: begin send_idle = 16; recv_stall = 16; end
			endcase
			if (n_sent > RAND_ITEMS / 2 && n_sent < RAND_ITEMS / 2 + 8) begin
				// hold off until the core has delivered everything
				in_ch.valid = 1'b0;
				wait (pending_res.size() == 0);
				@(negedge clk);
			end
			if ($urandom_range(99) < 10) begin
				load_byte_at(16'($urandom), 8'($urandom));  // stray RAM write
			end else begin
				run_instr(random_word(), $urandom_range(99) < 30);
			end
		end

		// halt, then a step and a load on the halted machine
		send_idle = 0;
		recv_stall = 0;
		run_instr(iw(OP_HCF, 5'd0, 6'd0, 16'h0000), 1'b0);
		c.op = 1'b1;
		c.addr = 16'h5A5A;
		c.lbyte = 8'hA5;
		send(c);
		load_byte_at(16'h0000, 8'h00);
		in_ch.valid = 1'b0;

		wait (pending_res.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d transactions (%0d instruction steps, %0d divide faults)",
			n_sent, n_steps, n_faults);
		$display("results checked: %0d, mismatches: %0d", n_got, errors);
		if (errors == 0 && pending_res.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
`default_nettype wire
